// File: rtl/ceg_pkg.sv
// Shared types, widths and arithmetic helpers for the Coulomb energy/gradient block.
`timescale 1ns / 1ps
`default_nettype none
package ceg_pkg;

  localparam int POS_W  = 32;            // Q16.16 coordinate
  localparam int CHG_W  = 7;             // integer nuclear charge
  localparam int FUNC_W = 2;
  localparam int IDX_W  = 4;             // electron index on a result word
  localparam int ACC_W  = 64;            // Q32.32 result
  localparam int DIFF_W = POS_W + 1;     // exact coordinate difference
  localparam int SQ_W   = 2 * POS_W + 2; // sum of three squares
  localparam int ROOT_W = SQ_W / 2;      // floor square root in Q16.16
  localparam int DIV_W  = 88;            // widest dividend is 87 bits: 39-bit numerator shifted by 48
  localparam int Q_SH   = 48;            // numerator scale for the first division
  localparam int B_SH   = 16;            // rescale before the second division

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR    = 2'd0,
    FN_NUCLEUS  = 2'd1,
    FN_ELECTRON = 2'd2,
    FN_COMPUTE  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OUTER,
    ST_RDA,
    ST_LDA,
    ST_CHKB,
    ST_LDB,
    ST_SQ,
    ST_ROOT,
    ST_ROOTW,
    ST_DIV,
    ST_DIVW,
    ST_NEXTJ,
    ST_ENDI,
    ST_EMIT
  } st_t;

  // gradient: electron vs nuclei, electron vs electrons; energy: three pair sets
  typedef enum logic [2:0] {
    PS_GN,
    PS_GE,
    PS_NN,
    PS_EN,
    PS_EE
  } pass_t;

  typedef enum logic [1:0] {
    DS_A,
    DS_B,
    DS_C
  } dstep_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [ACC_W-1:0] sum;
  } sadd_t;

  function automatic sadd_t sat_add(input logic signed [ACC_W-1:0] a,
                                    input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    sadd_t r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r.ovf = 1'b1;
      r.sum = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r.ovf = 1'b0;
      r.sum = s[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] m;
    m = v[DIFF_W-1] ? -v : v;
    return m[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/ceg_if.sv
// Command and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface ceg_cmd_if;
  import ceg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [CHG_W-1:0]        charge;
  modport source (output valid, func, pos_x, pos_y, pos_z, charge, input ready);
  modport sink   (input valid, func, pos_x, pos_y, pos_z, charge, output ready);
endinterface

interface ceg_res_if;
  import ceg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [IDX_W-1:0]        electron_index;
  logic signed [ACC_W-1:0] grad_x;
  logic signed [ACC_W-1:0] grad_y;
  logic signed [ACC_W-1:0] grad_z;
  logic signed [ACC_W-1:0] energy;
  logic                    error;
  logic                    last;
  modport source (output valid, kind, electron_index, grad_x, grad_y, grad_z, energy,
                  error, last, input ready);
  modport sink   (input valid, kind, electron_index, grad_x, grad_y, grad_z, energy,
                  error, last, output ready);
endinterface
`default_nettype wire

// File: rtl/coulomb_energy_gradient.sv
// Top level: particle stores, pair sequencer and accumulators.
//
// Command channel (cmd): each word carries func, a Q16.16 position and a charge.
// Clear, add nucleus and add electron act when the word is accepted; an add to a full
// store is dropped and raises the error bit on later results until a clear.
// Compute walks every particle pair out of the two stores, reading each
// particle through the one read port of its memory, and emits one gradient
// word per electron on res, then the energy word with last set.
// Cost per pair is set by the shared root and divider units: one square root
// for the distance, then the divisions. A gradient pair needs nine divisions,
// an energy pair one.
// cmd.ready is high only while no compute is running; a result word that waits
// on res does not hold cmd. When res stalls, the sequencer holds at the next
// result word until the output register frees.
// Reset (rst, synchronous) empties both stores and clears the drop flag;
// no clearing pass is needed since entries are read only below the counts.
`timescale 1ns / 1ps
`default_nettype none
module coulomb_energy_gradient #(
  parameter int MAX_NUCLEI    = 16,
  parameter int MAX_ELECTRONS = 16
) (
  input  logic      clk,
  input  logic      rst,
  ceg_cmd_if.sink   cmd,
  ceg_res_if.source res
);
  import ceg_pkg::*;

  localparam int NAW = (MAX_NUCLEI > 1) ? $clog2(MAX_NUCLEI) : 1;
  localparam int EAW = (MAX_ELECTRONS > 1) ? $clog2(MAX_ELECTRONS) : 1;
  localparam int NCW = $clog2(MAX_NUCLEI + 1);
  localparam int ECW = $clog2(MAX_ELECTRONS + 1);
  localparam int LW  = (NCW > ECW) ? NCW : ECW;
  localparam int NMW = 3 * POS_W + CHG_W;
  localparam int EMW = 3 * POS_W;

  st_t    state, state_next;
  pass_t  pass;
  dstep_t dstep;

  logic [NCW-1:0] ncount;
  logic [ECW-1:0] ecount;
  logic           dropped;
  logic [LW-1:0]  i, j;
  logic [1:0]     k;

  logic signed [POS_W-1:0]  ax, ay, az;
  logic [CHG_W-1:0]         ach, bch;
  logic signed [DIFF_W-1:0] diff [3];
  logic [SQ_W-1:0]          sq;
  logic signed [ACC_W-1:0]  g [3];
  logic signed [ACC_W-1:0]  e;
  logic                     err;

  logic [NMW-1:0] nuc_rd;
  logic [EMW-1:0] ele_rd;
  logic [LW-1:0]  rd_idx;
  logic           nuc_we, ele_we, nuc_room, ele_room, accept;

  logic              root_done, div_done;
  logic [ROOT_W-1:0] root_val;
  logic [DIV_W-1:0]  quot, dividend;

  logic              a_is_nuc, b_is_nuc, is_grad, outer_ok, inner_ok, skip_self, out_free;
  logic [LW-1:0]     outer_lim, inner_lim, j_start;
  logic [CHG_W-1:0]  qg;
  logic [2*CHG_W-1:0] qe;
  logic [POS_W+CHG_W-1:0] num;
  logic [POS_W-1:0]  mag;
  logic [2*POS_W-1:0] mag_sq;
  logic              neg, csat;
  logic signed [ACC_W-1:0] m, term_g, term_e, add_in, add_term;
  sadd_t             sa;

  // stores
  assign accept   = cmd.valid && cmd.ready;
  assign nuc_room = ncount < NCW'(MAX_NUCLEI);
  assign ele_room = ecount < ECW'(MAX_ELECTRONS);
  assign nuc_we   = accept && (cmd.func == FN_NUCLEUS) && nuc_room;
  assign ele_we   = accept && (cmd.func == FN_ELECTRON) && ele_room;
  assign rd_idx   = (state == ST_RDA) ? i : j;

  ceg_ram #(.WIDTH(NMW), .DEPTH(MAX_NUCLEI)) u_nuc (
    .clk   (clk),
    .we    (nuc_we),
    .waddr (ncount[NAW-1:0]),
    .wdata ({cmd.pos_x, cmd.pos_y, cmd.pos_z, cmd.charge}),
    .raddr (rd_idx[NAW-1:0]),
    .rdata (nuc_rd)
  );

  ceg_ram #(.WIDTH(EMW), .DEPTH(MAX_ELECTRONS)) u_ele (
    .clk   (clk),
    .we    (ele_we),
    .waddr (ecount[EAW-1:0]),
    .wdata ({cmd.pos_x, cmd.pos_y, cmd.pos_z}),
    .raddr (rd_idx[EAW-1:0]),
    .rdata (ele_rd)
  );

  ceg_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_ROOT),
    .radicand (sq),
    .done     (root_done),
    .root     (root_val)
  );

  ceg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DIV),
    .dividend (dividend),
    .divisor  (root_val),
    .done     (div_done),
    .quot     (quot)
  );

  // pass decode
  assign a_is_nuc  = (pass == PS_NN);
  assign b_is_nuc  = (pass == PS_GN) || (pass == PS_EN) || (pass == PS_NN);
  assign is_grad   = (pass == PS_GN) || (pass == PS_GE);
  assign outer_lim = a_is_nuc ? LW'(ncount) : LW'(ecount);
  assign inner_lim = b_is_nuc ? LW'(ncount) : LW'(ecount);
  assign j_start   = ((pass == PS_NN) || (pass == PS_EE)) ? i + LW'(1) : '0;
  assign outer_ok  = i < outer_lim;
  assign inner_ok  = j < inner_lim;
  assign skip_self = (pass == PS_GE) && (j == i);
  assign out_free  = !res.valid || res.ready;
  assign cmd.ready = (state == ST_IDLE);

  // term arithmetic
  always_comb begin
    mag    = abs_diff(diff[k]);
    mag_sq = mag * mag;
    qg     = (pass == PS_GN) ? bch : CHG_W'(1);
    num    = qg * mag;
    unique case (pass)
      PS_NN:   qe = ach * bch;
      PS_EN:   qe = (2*CHG_W)'(bch);
      default: qe = (2*CHG_W)'(1);
    endcase
    if (!is_grad) begin
      dividend = DIV_W'({qe, {Q_SH{1'b0}}});
    end else begin
      unique case (dstep)
        DS_A:    dividend = DIV_W'({num, {Q_SH{1'b0}}});
        DS_B:    dividend = DIV_W'({quot[ACC_W-1:0], {B_SH{1'b0}}});
        default: dividend = quot;
      endcase
    end
    // delta is r - R against nuclei and r' - r against other electrons
    neg    = (pass == PS_GN) ? diff[k][DIFF_W-1]
                             : (!diff[k][DIFF_W-1] && (diff[k] != '0));
    csat   = |quot[DIV_W-1:ACC_W-1];
    m      = csat ? ACC_MAX : {1'b0, quot[ACC_W-2:0]};
    term_g = neg ? -m : m;
    term_e = (pass == PS_EN) ? -signed'(quot[ACC_W-1:0]) : signed'(quot[ACC_W-1:0]);
    add_in   = is_grad ? g[k] : e;
    add_term = is_grad ? term_g : term_e;
    sa       = sat_add(add_in, add_term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.valid && (cmd.func == FN_COMPUTE)) state_next = ST_OUTER;
      end
      ST_OUTER: begin
        if (outer_ok) state_next = ST_RDA;
        else if (pass == PS_EE) state_next = ST_EMIT;
      end
      ST_RDA:   state_next = ST_LDA;
      ST_LDA:   state_next = ST_CHKB;
      ST_CHKB: begin
        if (!inner_ok) state_next = ST_ENDI;
        else if (!skip_self) state_next = ST_LDB;
      end
      ST_LDB:   state_next = ST_SQ;
      ST_SQ: begin
        if (k == 2'd2) state_next = ST_ROOT;
      end
      ST_ROOT:  state_next = ST_ROOTW;
      ST_ROOTW: begin
        if (root_done) state_next = (root_val == '0) ? ST_NEXTJ : ST_DIV;
      end
      ST_DIV:   state_next = ST_DIVW;
      ST_DIVW: begin
        if (div_done) begin
          if (!is_grad || ((dstep == DS_C) && (k == 2'd2))) state_next = ST_NEXTJ;
          else state_next = ST_DIV;
        end
      end
      ST_NEXTJ: state_next = ST_CHKB;
      ST_ENDI: begin
        if (pass == PS_GN) state_next = ST_CHKB;
        else if (pass == PS_GE) state_next = ST_EMIT;
        else state_next = ST_OUTER;
      end
      ST_EMIT: begin
        if (out_free) state_next = is_grad ? ST_OUTER : ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // counts, drop flag, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ncount    <= '0;
      ecount    <= '0;
      dropped   <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready) res.valid <= 1'b0;
      if ((state == ST_EMIT) && out_free) res.valid <= 1'b1;
      if (accept) begin
        unique case (func_t'(cmd.func))
          FN_CLEAR: begin
            ncount  <= '0;
            ecount  <= '0;
            dropped <= 1'b0;
          end
          FN_NUCLEUS: begin
            if (nuc_room) ncount <= ncount + NCW'(1);
            else dropped <= 1'b1;
          end
          FN_ELECTRON: begin
            if (ele_room) ecount <= ecount + ECW'(1);
            else dropped <= 1'b1;
          end
          FN_COMPUTE: ;
        endcase
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pass  <= PS_GN;
      dstep <= DS_A;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && (cmd.func == FN_COMPUTE)) begin
            pass <= PS_GN;
            i    <= '0;
            err  <= dropped;
            g[0] <= '0;
            g[1] <= '0;
            g[2] <= '0;
          end
        end
        ST_OUTER: begin
          if (!outer_ok) begin
            unique case (pass)
              PS_NN: begin
                pass <= PS_EN;
                i    <= '0;
              end
              PS_EN: begin
                pass <= PS_EE;
                i    <= '0;
              end
              PS_EE: ;
              default: begin
                pass <= PS_NN;
                i    <= '0;
                err  <= dropped;
                e    <= '0;
              end
            endcase
          end
        end
        ST_LDA: begin
          if (a_is_nuc) begin
            {ax, ay, az, ach} <= nuc_rd;
          end else begin
            {ax, ay, az} <= ele_rd;
            ach          <= '0;
          end
          j <= j_start;
        end
        ST_CHKB: begin
          if (inner_ok && skip_self) j <= j + LW'(1);
        end
        ST_LDB: begin
          if (b_is_nuc) begin
            diff[0] <= {ax[POS_W-1], ax} - {nuc_rd[NMW-1], nuc_rd[NMW-1 -: POS_W]};
            diff[1] <= {ay[POS_W-1], ay} - {nuc_rd[NMW-POS_W-1],
                                            nuc_rd[NMW-POS_W-1 -: POS_W]};
            diff[2] <= {az[POS_W-1], az} - {nuc_rd[NMW-2*POS_W-1],
                                            nuc_rd[NMW-2*POS_W-1 -: POS_W]};
            bch     <= nuc_rd[CHG_W-1:0];
          end else begin
            diff[0] <= {ax[POS_W-1], ax} - {ele_rd[EMW-1], ele_rd[EMW-1 -: POS_W]};
            diff[1] <= {ay[POS_W-1], ay} - {ele_rd[EMW-POS_W-1],
                                            ele_rd[EMW-POS_W-1 -: POS_W]};
            diff[2] <= {az[POS_W-1], az} - {ele_rd[POS_W-1], ele_rd[POS_W-1:0]};
            bch     <= '0;
          end
          k  <= '0;
          sq <= '0;
        end
        ST_SQ: begin
          sq <= sq + SQ_W'(mag_sq);
          k  <= (k == 2'd2) ? 2'd0 : k + 2'd1;
        end
        ST_ROOTW: begin
          if (root_done) begin
            if (root_val == '0) err <= 1'b1;
            k     <= '0;
            dstep <= DS_A;
          end
        end
        ST_DIVW: begin
          if (div_done) begin
            if (!is_grad) begin
              e   <= sa.sum;
              err <= err | sa.ovf;
            end else begin
              unique case (dstep)
                DS_A: dstep <= DS_B;
                DS_B: dstep <= DS_C;
                default: begin
                  g[k]  <= sa.sum;
                  err   <= err | sa.ovf | csat;
                  dstep <= DS_A;
                  k     <= (k == 2'd2) ? 2'd0 : k + 2'd1;
                end
              endcase
            end
          end
        end
        ST_NEXTJ: j <= j + LW'(1);
        ST_ENDI: begin
          if (pass == PS_GN) begin
            pass <= PS_GE;
            j    <= '0;
          end else if (pass != PS_GE) begin
            i <= i + LW'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            res.error <= err;
            if (is_grad) begin
              res.kind           <= 1'b0;
              res.electron_index <= IDX_W'(i);
              res.grad_x         <= g[0];
              res.grad_y         <= g[1];
              res.grad_z         <= g[2];
              res.energy         <= '0;
              res.last           <= 1'b0;
              i    <= i + LW'(1);
              pass <= PS_GN;
              err  <= dropped;
              g[0] <= '0;
              g[1] <= '0;
              g[2] <= '0;
            end else begin
              res.kind           <= 1'b1;
              res.electron_index <= '0;
              res.grad_x         <= '0;
              res.grad_y         <= '0;
              res.grad_z         <= '0;
              res.energy         <= e;
              res.last           <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/ceg_ram.sv
// Particle store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ceg_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/ceg_sqrt.sv
// Floor square root of the squared distance, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ceg_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ceg_pkg::SQ_W-1:0]    radicand,
  output logic                        done,
  output logic [ceg_pkg::ROOT_W-1:0]  root
);
  import ceg_pkg::*;
  localparam int CW = $clog2(ROOT_W + 1);

  logic [SQ_W-1:0]   rad;
  logic [ROOT_W+2:0] rem;
  logic [ROOT_W+2:0] rem2;
  logic [ROOT_W+2:0] test;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              ge;

  assign rem2 = {rem[ROOT_W:0], rad[SQ_W-1 -: 2]};
  assign test = {1'b0, root, 2'b01};
  assign ge   = rem2 >= test;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rad  <= rad << 2;
        rem  <= ge ? (rem2 - test) : rem2;
        root <= {root[ROOT_W-2:0], ge};
        cnt  <= cnt + CW'(1);
        if (cnt == CW'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/ceg_div.sv
// Restoring divider by the distance, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ceg_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ceg_pkg::DIV_W-1:0]   dividend,
  input  logic [ceg_pkg::ROOT_W-1:0]  divisor,
  output logic                        done,
  output logic [ceg_pkg::DIV_W-1:0]   quot
);
  import ceg_pkg::*;
  localparam int CW = $clog2(DIV_W + 1);

  logic [ROOT_W-1:0] dvs;
  logic [ROOT_W-1:0] rem;
  logic [ROOT_W:0]   r2;
  logic [ROOT_W:0]   rdiff;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              ge;

  assign r2    = {rem, quot[DIV_W-1]};
  assign rdiff = r2 - {1'b0, dvs};
  assign ge    = r2 >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? rdiff[ROOT_W-1:0] : r2[ROOT_W-1:0];
        quot <= {quot[DIV_W-2:0], ge};
        cnt  <= cnt + CW'(1);
        if (cnt == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/ceg_check.sv
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ceg_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic                             kind,
  input logic [ceg_pkg::IDX_W-1:0]        electron_index,
  input logic signed [ceg_pkg::ACC_W-1:0] grad_x,
  input logic signed [ceg_pkg::ACC_W-1:0] grad_y,
  input logic signed [ceg_pkg::ACC_W-1:0] grad_z,
  input logic signed [ceg_pkg::ACC_W-1:0] energy,
  input logic                             last
);
  import ceg_pkg::*;

  // hold a stalled word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(energy) && $stable(grad_x)
                                && $stable(last))
    else $error("stalled result word changed");

  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (last == kind))
    else $error("last does not mark the energy word");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (kind ? (grad_x == '0 && grad_y == '0 && grad_z == '0
                           && electron_index == '0)
                        : (energy == '0)))
    else $error("unused fields of a result word are not zero");
endmodule

bind coulomb_energy_gradient ceg_check u_ceg_check (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .kind           (res.kind),
  .electron_index (res.electron_index),
  .grad_x         (res.grad_x),
  .grad_y         (res.grad_y),
  .grad_z         (res.grad_z),
  .energy         (res.energy),
  .last           (res.last)
);
`default_nettype wire

// File: tb/ceg_tb_if_types.sv
// Result word record shared by the predictor and the result checker.
`timescale 1ns / 1ps
package ceg_tb_types;
  import ceg_pkg::*;

  typedef struct {
    logic                    kind;
    logic [IDX_W-1:0]        idx;
    logic signed [ACC_W-1:0] gx;
    logic signed [ACC_W-1:0] gy;
    logic signed [ACC_W-1:0] gz;
    logic signed [ACC_W-1:0] energy;
    logic                    error;
    logic                    last;
  } result_word_t;
endpackage

// File: tb/testbench.sv
// Self-checking testbench for the Coulomb energy and gradient block.
`timescale 1ns / 1ps
module testbench;
  import ceg_pkg::*;
  import ceg_tb_types::*;

  localparam int STALL_LIMIT = 400000;
  localparam int NUM_ITEMS   = 420;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ceg_cmd_if cmd ();
  ceg_res_if res ();

  coulomb_energy_gradient uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the particle stores
  logic signed [POS_W-1:0] nuc_x [16];
  logic signed [POS_W-1:0] nuc_y [16];
  logic signed [POS_W-1:0] nuc_z [16];
  logic [CHG_W-1:0]        nuc_chg [16];
  logic signed [POS_W-1:0] ele_x [16];
  logic signed [POS_W-1:0] ele_y [16];
  logic signed [POS_W-1:0] ele_z [16];
  int                      nuc_cnt = 0;
  int                      ele_cnt = 0;
  logic                    drop_seen = 1'b0;

  result_word_t pending_words[$];

  int  fails = 0;
  int  mismatches = 0;
  int  items_sent = 0;
  int  computes = 0;
  int  rows_checked = 0;
  int  energies_checked = 0;
  int  flagged_words = 0;
  int  stall_count = 0;
  int  hold_left = 0;
  bit  steady = 1'b0;

  // ---------------------------------------------------------------- arithmetic

  function automatic logic [63:0] pair_dist(input logic signed [31:0] ax, ay, az,
                                            input logic signed [31:0] bx, by, bz);
    logic [127:0] d2;
    logic [63:0]  m;
    logic [63:0]  r;
    logic [63:0]  c;
    longint       dv [3];
    d2 = '0;
    r  = '0;
    dv[0] = longint'(ax) - longint'(bx);
    dv[1] = longint'(ay) - longint'(by);
    dv[2] = longint'(az) - longint'(bz);
    for (int k = 0; k < 3; k++) begin
      m  = (dv[k] < 0) ? 64'(-dv[k]) : 64'(dv[k]);
      d2 = d2 + {64'd0, m} * {64'd0, m};
    end
    for (int k = 40; k >= 0; k--) begin
      c = r | (64'd1 << k);
      if ({64'd0, c} * {64'd0, c} <= d2) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 inout logic flag);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      flag = 1'b1;
      return s[64] ? ACC_MIN : ACC_MAX;
    end
    return s[63:0];
  endfunction

  // q*delta/d^3 in Q32.32, three truncating divisions as the hardware does
  function automatic logic signed [63:0] grad_component(input logic [63:0] q,
                                                        input longint delta,
                                                        input logic [63:0] d,
                                                        inout logic flag);
    logic [63:0]  n;
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] c;
    logic [63:0]  mag;
    n = q * ((delta < 0) ? 64'(-delta) : 64'(delta));
    a = ({64'd0, n} << 48) / {64'd0, d};
    b = ({64'd0, a[63:0]} << 16) / {64'd0, d};
    c = b / {64'd0, d};
    if (c[127:63] != '0) begin
      flag = 1'b1;
      mag = 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      mag = c[63:0];
    end
    return (delta < 0) ? -mag : mag;
  endfunction

  function automatic logic signed [63:0] inv_dist_term(input logic [63:0] q,
                                                       input logic [63:0] d);
    return (q << 48) / d;
  endfunction

  // -------------------------------------------------------------- prediction

  task automatic predict_compute();
    result_word_t w;
    logic         flag;
    logic [63:0]  d;
    logic signed [63:0] g [3];
    logic signed [63:0] e;
    logic signed [63:0] term;
    longint       r [3];
    longint       p [3];
    computes++;
    for (int i = 0; i < ele_cnt; i++) begin
      r[0] = longint'(ele_x[i]); r[1] = longint'(ele_y[i]); r[2] = longint'(ele_z[i]);
      g[0] = '0; g[1] = '0; g[2] = '0;
      flag = drop_seen;
      for (int j = 0; j < nuc_cnt; j++) begin
        p[0] = longint'(nuc_x[j]); p[1] = longint'(nuc_y[j]); p[2] = longint'(nuc_z[j]);
        d = pair_dist(ele_x[i], ele_y[i], ele_z[i], nuc_x[j], nuc_y[j], nuc_z[j]);
        if (d == 0) begin
          flag = 1'b1;
          continue;
        end
        for (int k = 0; k < 3; k++) begin
          term = grad_component(64'(nuc_chg[j]), r[k] - p[k], d, flag);
          g[k] = sat_sum(g[k], term, flag);
        end
      end
      for (int j = 0; j < ele_cnt; j++) begin
        if (j == i) continue;
        p[0] = longint'(ele_x[j]); p[1] = longint'(ele_y[j]); p[2] = longint'(ele_z[j]);
        d = pair_dist(ele_x[i], ele_y[i], ele_z[i], ele_x[j], ele_y[j], ele_z[j]);
        if (d == 0) begin
          flag = 1'b1;
          continue;
        end
        for (int k = 0; k < 3; k++) begin
          term = grad_component(64'd1, p[k] - r[k], d, flag);
          g[k] = sat_sum(g[k], term, flag);
        end
      end
      w = '{kind: 1'b0, idx: i[IDX_W-1:0], gx: g[0], gy: g[1], gz: g[2], energy: '0,
            error: flag, last: 1'b0};
      pending_words.push_back(w);
    end
    flag = drop_seen;
    e = '0;
    for (int i = 0; i < nuc_cnt; i++)
      for (int j = i + 1; j < nuc_cnt; j++) begin
        d = pair_dist(nuc_x[i], nuc_y[i], nuc_z[i], nuc_x[j], nuc_y[j], nuc_z[j]);
        if (d == 0) begin
          flag = 1'b1;
          continue;
        end
        e = sat_sum(e, inv_dist_term(64'(nuc_chg[i]) * 64'(nuc_chg[j]), d), flag);
      end
    for (int i = 0; i < ele_cnt; i++)
      for (int j = 0; j < nuc_cnt; j++) begin
        d = pair_dist(ele_x[i], ele_y[i], ele_z[i], nuc_x[j], nuc_y[j], nuc_z[j]);
        if (d == 0) begin
          flag = 1'b1;
          continue;
        end
        e = sat_sum(e, -inv_dist_term(64'(nuc_chg[j]), d), flag);
      end
    for (int i = 0; i < ele_cnt; i++)
      for (int j = i + 1; j < ele_cnt; j++) begin
        d = pair_dist(ele_x[i], ele_y[i], ele_z[i], ele_x[j], ele_y[j], ele_z[j]);
        if (d == 0) begin
          flag = 1'b1;
          continue;
        end
        e = sat_sum(e, inv_dist_term(64'd1, d), flag);
      end
    w = '{kind: 1'b1, idx: '0, gx: '0, gy: '0, gz: '0, energy: e, error: flag, last: 1'b1};
    pending_words.push_back(w);
  endtask

  task automatic apply_word(input func_t fn, input logic signed [31:0] x, y, z,
                            input logic [CHG_W-1:0] chg);
    case (fn)
      FN_CLEAR: begin
        nuc_cnt = 0;
        ele_cnt = 0;
        drop_seen = 1'b0;
      end
      FN_NUCLEUS: begin
        if (nuc_cnt < 16) begin
          nuc_x[nuc_cnt] = x; nuc_y[nuc_cnt] = y; nuc_z[nuc_cnt] = z;
          nuc_chg[nuc_cnt] = chg;
          nuc_cnt++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      FN_ELECTRON: begin
        if (ele_cnt < 16) begin
          ele_x[ele_cnt] = x; ele_y[ele_cnt] = y; ele_z[ele_cnt] = z;
          ele_cnt++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      default: predict_compute();
    endcase
  endtask

  // ------------------------------------------------------------------ driving

  task automatic send_word(input func_t fn, input logic signed [31:0] x, y, z,
                           input logic [CHG_W-1:0] chg);
    if (!steady && $urandom_range(99) < 34) begin
      @(negedge clk);
      cmd.valid = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    cmd.valid  = 1'b1;
    cmd.func   = fn;
    cmd.pos_x  = x;
    cmd.pos_y  = y;
    cmd.pos_z  = z;
    cmd.charge = chg;
    do @(posedge clk); while (!cmd.ready);
    apply_word(fn, x, y, z, chg);
    items_sent++;
  endtask

  task automatic send_clear();
    send_word(FN_CLEAR, $urandom, $urandom, $urandom, CHG_W'($urandom));
  endtask

  task automatic send_compute();
    send_word(FN_COMPUTE, $urandom, $urandom, $urandom, CHG_W'($urandom));
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2:       return $signed($urandom_range(2 ** 20)) - 32'sd524288;
      default: return $signed($urandom_range(2 ** 18)) - 32'sd131072;
    endcase
  endfunction

  // drop the accepted word first so it is not taken again
  task automatic wait_drained();
    @(negedge clk);
    cmd.valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // ------------------------------------------------------------------- checks

  always @(negedge clk) begin
    if (hold_left > 0) begin
      res.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      res.ready <= steady || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    result_word_t w;
    if (!rst && res.valid && res.ready) begin
      if (pending_words.size() == 0) begin
        fails++;
        $display("unexpected result word: kind=%0d idx=%0d", res.kind, res.electron_index);
      end else begin
        w = pending_words.pop_front();
        if (res.kind !== w.kind || res.electron_index !== w.idx || res.grad_x !== w.gx ||
            res.grad_y !== w.gy || res.grad_z !== w.gz || res.energy !== w.energy ||
            res.error !== w.error || res.last !== w.last) begin
          fails++;
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: want kind=%0d idx=%0d g=(%0d,%0d,%0d) e=%0d err=%0d last=%0d",
                     w.kind, w.idx, w.gx, w.gy, w.gz, w.energy, w.error, w.last);
            $display("          got  kind=%0d idx=%0d g=(%0d,%0d,%0d) e=%0d err=%0d last=%0d",
                     res.kind, res.electron_index, res.grad_x, res.grad_y, res.grad_z,
                     res.energy, res.error, res.last);
          end
        end
        if (w.kind) energies_checked++;
        else rows_checked++;
        if (w.error) flagged_words++;
      end
    end
  end

  // reset the count on any accepted word on either side
  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      stall_count <= 0;
    end else if (!rst) begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------- tests

  task automatic test_simple_cases();
    send_clear();
    send_compute();                                  // empty stores: energy only
    send_word(FN_NUCLEUS, 0, 0, 0, 7'd1);
    send_word(FN_ELECTRON, 32'sh0001_0000, 0, 0, 7'd0);
    send_compute();
    send_word(FN_NUCLEUS, 32'sh0002_0000, 32'sh0001_0000, 0, 7'd0);  // zero charge
    send_word(FN_ELECTRON, 0, 0, 0, 7'd0);                           // on top of a nucleus
    send_compute();
    wait_drained();
  endtask

  task automatic test_extremes();
    send_clear();
    send_word(FN_NUCLEUS, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 7'd127);
    send_word(FN_ELECTRON, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 7'd0);
    send_word(FN_ELECTRON, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 7'd0);
    send_compute();
    // tight cluster of heavy nuclei: clips the gradient and the energy sum
    send_clear();
    send_word(FN_NUCLEUS, 0, 0, 0, 7'd127);
    send_word(FN_NUCLEUS, 1, 0, 0, 7'd127);
    send_word(FN_NUCLEUS, 0, 1, 0, 7'd127);
    send_word(FN_ELECTRON, 0, 0, 1, 7'd0);
    send_compute();
    wait_drained();
  endtask

  task automatic test_full_stores();
    send_clear();
    for (int i = 0; i < 17; i++)
      send_word(FN_NUCLEUS, rand_coord(), rand_coord(), rand_coord(), CHG_W'($urandom));
    send_word(FN_ELECTRON, rand_coord(), rand_coord(), rand_coord(), 7'd0);
    send_compute();
    send_clear();
    send_compute();                                  // clear drops the flag
    steady = 1'b1;
    for (int i = 0; i < 17; i++)
      send_word(FN_ELECTRON, rand_coord(), rand_coord(), rand_coord(), CHG_W'($urandom));
    send_compute();
    steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_output_stall();
    send_clear();
    send_word(FN_NUCLEUS, 32'sh0001_0000, 0, 0, 7'd3);
    send_word(FN_ELECTRON, 0, 32'sh0000_8000, 0, 7'd0);
    @(negedge clk);
    cmd.valid = 1'b0;
    hold_left = 3000;
    send_compute();
    // these wait on cmd until the compute ends
    send_word(FN_ELECTRON, 32'sh0000_4000, 0, 32'sh0001_0000, 7'd0);
    send_compute();
    wait_drained();
  endtask

  task automatic test_random();
    int n_nuc;
    int n_ele;
    while (items_sent < NUM_ITEMS) begin
      steady = (items_sent > 250 && items_sent < 300);
      if ($urandom_range(99) < 75) begin
        send_clear();
        n_nuc = $urandom_range(3);
        n_ele = $urandom_range(1, 3);
        for (int i = 0; i < n_nuc; i++)
          send_word(FN_NUCLEUS, rand_coord(), rand_coord(), rand_coord(), CHG_W'($urandom));
        for (int i = 0; i < n_ele; i++)
          send_word(FN_ELECTRON, rand_coord(), rand_coord(), rand_coord(), CHG_W'($urandom));
        send_compute();
      end else begin
        case ($urandom_range(3))
          0: send_clear();
          1: if (nuc_cnt < 4)
               send_word(FN_NUCLEUS, rand_coord(), rand_coord(), rand_coord(),
                         CHG_W'($urandom));
             else send_clear();
          2: if (ele_cnt < 4)
               send_word(FN_ELECTRON, rand_coord(), rand_coord(), rand_coord(),
                         CHG_W'($urandom));
             else send_clear();
          default: send_compute();
        endcase
      end
    end
    steady = 1'b0;
    @(negedge clk);
    cmd.valid = 1'b0;
    wait_drained();
  endtask

  initial begin
    cmd.valid  = 1'b0;
    cmd.func   = FN_CLEAR;
    cmd.pos_x  = '0;
    cmd.pos_y  = '0;
    cmd.pos_z  = '0;
    cmd.charge = '0;
    res.ready  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_simple_cases();
    test_extremes();
    test_full_stores();
    test_output_stall();
    test_random();

    repeat (100) @(posedge clk);
    $display("%0d command words, %0d computes: %0d gradient rows and %0d energies checked",
             items_sent, computes, rows_checked, energies_checked);
    $display("%0d words carried the error bit, %0d mismatches", flagged_words, mismatches);
    if (fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
